>>> rtl/ktwa_pkg.sv
// Package for the keyed table with aging: codes, register map, reset values
// and the control struct that the top level hands to every table cell.
// No dependencies.
package ktwa_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH = 64;

  // Field widths fixed by the item format.
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 7;

  // Configuration port: one register, word addressed.
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = '0;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

  typedef enum logic {
    ACT_REPORT = 1'b0,
    ACT_PURGE  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_PURGED  = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  typedef enum logic {
    FS_IDLE   = 1'b0,
    FS_COMMIT = 1'b1
  } fsm_e;

  // Per-cell commands.
  typedef struct packed {
    logic probe;  // compare key and age, capture the flags
    logic upd;    // refresh the stamp
    logic load;   // take a new key and stamp
    logic shift;  // take key and stamp from the next cell
  } cell_ctl_t;

endpackage

>>> rtl/ktwa_chan_if.sv
// Handshake channels of the keyed table with aging: one for input items and
// one for result items. Depends on ktwa_pkg for the field widths.
interface ktwa_item_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ktwa_pkg::ID_W-1:0]     vehicle_id;
  logic [ktwa_pkg::TIME_W-1:0]   now_seconds;

  modport source (output valid, action, vehicle_id, now_seconds, input ready);
  modport sink   (input valid, action, vehicle_id, now_seconds, output ready);
endinterface

interface ktwa_result_if;
  logic                            valid;
  logic                            ready;
  logic [ktwa_pkg::STATUS_W-1:0]   status;
  logic [ktwa_pkg::ID_W-1:0]       affected_id;
  logic [ktwa_pkg::TOTAL_W-1:0]    entry_total;

  modport source (output valid, status, affected_id, entry_total, input ready);
  modport sink   (input valid, status, affected_id, entry_total, output ready);
endinterface

>>> rtl/ktwa_cell.sv
// One table cell: holds a key and its stamp, compares against the probed ID,
// checks its age and moves data in from its neighbor. Depends on ktwa_pkg.
module ktwa_cell (
  input  logic                        clk_i,
  input  ktwa_pkg::cell_ctl_t         ctl_i,
  input  logic                        live_i,
  input  logic [ktwa_pkg::ID_W-1:0]   probe_id_i,
  input  logic [ktwa_pkg::TIME_W-1:0] probe_now_i,
  input  logic [ktwa_pkg::TMO_W-1:0]  timeout_i,
  input  logic [ktwa_pkg::ID_W-1:0]   wr_id_i,
  input  logic [ktwa_pkg::TIME_W-1:0] wr_now_i,
  input  logic [ktwa_pkg::ID_W-1:0]   nb_key_i,
  input  logic [ktwa_pkg::TIME_W-1:0] nb_stamp_i,
  output logic [ktwa_pkg::ID_W-1:0]   key_o,
  output logic [ktwa_pkg::TIME_W-1:0] stamp_o,
  output logic                        hit_o,
  output logic                        old_o
);

  logic [ktwa_pkg::ID_W-1:0]   key_q, key_d;
  logic [ktwa_pkg::TIME_W-1:0] stamp_q, stamp_d;
  logic                        hit_q, hit_d;
  logic                        old_q, old_d;
  logic [ktwa_pkg::TIME_W-1:0] age;

  // Age wraps modulo 2^32, so a stamp in the future counts as very old.
  assign age = probe_now_i - stamp_q;

  always_comb begin
    key_d   = key_q;
    stamp_d = stamp_q;
    hit_d   = hit_q;
    old_d   = old_q;
    if (ctl_i.probe) begin
      hit_d = live_i && (key_q == probe_id_i);
      old_d = live_i && (age > {{(ktwa_pkg::TIME_W - ktwa_pkg::TMO_W){1'b0}}, timeout_i});
    end
    priority if (ctl_i.shift) begin
      key_d   = nb_key_i;
      stamp_d = nb_stamp_i;
    end else if (ctl_i.load) begin
      key_d   = wr_id_i;
      stamp_d = wr_now_i;
    end else if (ctl_i.upd) begin
      stamp_d = wr_now_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    stamp_q <= stamp_d;
    hit_q   <= hit_d;
    old_q   <= old_d;
  end

  assign key_o   = key_q;
  assign stamp_o = stamp_q;
  assign hit_o   = hit_q;
  assign old_o   = old_q;

endmodule

>>> rtl/ktwa_first.sv
// Finds the first timed-out cell: a log-depth prefix OR over the flags, and
// the key of that first cell. Depends on ktwa_pkg.
module ktwa_first #(
  parameter int unsigned TABLE_DEPTH = ktwa_pkg::TABLE_DEPTH
) (
  input  logic [TABLE_DEPTH-1:0]                     old_i,
  input  logic [TABLE_DEPTH-1:0][ktwa_pkg::ID_W-1:0] key_i,
  output logic [TABLE_DEPTH-1:0]                     after_o,
  output logic                                       found_o,
  output logic [ktwa_pkg::ID_W-1:0]                  key_o
);

  localparam int unsigned LEVELS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [LEVELS:0][TABLE_DEPTH-1:0] pre;
  logic [TABLE_DEPTH-1:0]           first;

  // after_o[j] is set when any cell at or below j has timed out.
  always_comb begin
    pre[0] = old_i;
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (j >= (1 << l)) begin
          pre[l+1][j] = pre[l][j] | pre[l][j - (1 << l)];
        end else begin
          pre[l+1][j] = pre[l][j];
        end
      end
    end
  end

  assign after_o = pre[LEVELS];
  assign found_o = pre[LEVELS][TABLE_DEPTH-1];

  always_comb begin
    key_o = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (j == 0) begin
        first[j] = old_i[j];
      end else begin
        first[j] = old_i[j] && !pre[LEVELS][j-1];
      end
      key_o = key_o | (key_i[j] & {ktwa_pkg::ID_W{first[j]}});
    end
  end

endmodule

>>> rtl/keyed_table_with_aging_core.sv
// Top level of the keyed table with aging: a row of table cells, the
// first-timeout finder, the item sequencer and the configuration register.
// Depends on ktwa_pkg, ktwa_chan_if, ktwa_cell and ktwa_first.
//
// The table holds up to TABLE_DEPTH vehicle IDs in arrival order, each with the
// time it was last reported. At the transfer of an item every cell compares its
// key with the reported ID and checks its age against the programmed timeout in
// parallel; in the commit state, once the output register is free, the first
// timed-out cell is picked, the cells are updated (stamp refresh, append at the
// end, or removal with every later cell taking its neighbor's data) and the
// result is placed in the output register. The next item is taken only once
// that result has been registered, so the table works on one item at a time.
// Reads of the table only touch cells below the entry count, so no clearing
// pass runs after reset.
module keyed_table_with_aging_core #(
  parameter int unsigned TABLE_DEPTH = ktwa_pkg::TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ktwa_item_if.sink                      item_i,
  ktwa_result_if.source                  result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ktwa_pkg::PADDR_W-1:0]   paddr,
  input  logic [ktwa_pkg::PDATA_W-1:0]   pwdata,
  output logic [ktwa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  ktwa_pkg::fsm_e                state_q, state_d;
  ktwa_pkg::action_e             act_q;
  logic [ktwa_pkg::ID_W-1:0]     id_q;
  logic [ktwa_pkg::TIME_W-1:0]   now_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [ktwa_pkg::TMO_W-1:0]    timeout_q;

  logic                          out_valid_q;
  logic [ktwa_pkg::STATUS_W-1:0] status_q;
  logic [ktwa_pkg::ID_W-1:0]     aff_q;
  logic [ktwa_pkg::TOTAL_W-1:0]  total_q;

  logic                          accept, out_free, commit, cfg_wr;
  ktwa_pkg::status_e             status_d;
  logic [ktwa_pkg::ID_W-1:0]     aff_d;
  logic [TABLE_DEPTH-1:0]        upd_vec, load_vec, shift_vec;

  logic [TABLE_DEPTH-1:0]                     hit_vec, old_vec, after_vec;
  logic [TABLE_DEPTH-1:0][ktwa_pkg::ID_W-1:0]   key_vec;
  logic [TABLE_DEPTH-1:0][ktwa_pkg::TIME_W-1:0] stamp_vec;
  logic                                       any_old;
  logic [ktwa_pkg::ID_W-1:0]                  gone_key;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
               && (paddr[ktwa_pkg::PADDR_W-1:2] == ktwa_pkg::REG_TIMEOUT);
  assign prdata = (paddr[ktwa_pkg::PADDR_W-1:2] == ktwa_pkg::REG_TIMEOUT)
                ? {{(ktwa_pkg::PDATA_W - ktwa_pkg::TMO_W){1'b0}}, timeout_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ktwa_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[ktwa_pkg::TMO_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  assign item_i.ready = (state_q == ktwa_pkg::FS_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign commit       = (state_q == ktwa_pkg::FS_COMMIT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ktwa_pkg::FS_IDLE: begin
        if (accept) begin
          state_d = ktwa_pkg::FS_COMMIT;
        end
      end
      ktwa_pkg::FS_COMMIT: begin
        if (out_free) begin
          state_d = ktwa_pkg::FS_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktwa_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= ktwa_pkg::action_e'(item_i.action);
      id_q  <= item_i.vehicle_id;
      now_q <= item_i.now_seconds;
    end
  end

  // ---------------- decision for the item in flight ----------------
  always_comb begin
    status_d  = ktwa_pkg::ST_NONE;
    aff_d     = '0;
    count_d   = count_q;
    upd_vec   = '0;
    load_vec  = '0;
    shift_vec = '0;
    if (act_q == ktwa_pkg::ACT_PURGE) begin
      if (any_old) begin
        status_d  = ktwa_pkg::ST_PURGED;
        aff_d     = gone_key;
        count_d   = count_q - CNT_W'(1);
        shift_vec = after_vec;
      end
    end else if (|hit_vec) begin
      status_d = ktwa_pkg::ST_UPDATED;
      aff_d    = id_q;
      upd_vec  = hit_vec;
    end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
      status_d = ktwa_pkg::ST_DROPPED;
      aff_d    = id_q;
    end else begin
      status_d = ktwa_pkg::ST_ADDED;
      aff_d    = id_q;
      count_d  = count_q + CNT_W'(1);
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        load_vec[j] = (count_q == CNT_W'(j));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      aff_q    <= aff_d;
      total_q  <= ktwa_pkg::TOTAL_W'(count_d);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.status      = status_q;
  assign result_o.affected_id = aff_q;
  assign result_o.entry_total = total_q;

  // ---------------- row of cells ----------------
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    ktwa_pkg::cell_ctl_t          ctl;
    logic [ktwa_pkg::ID_W-1:0]    nb_key;
    logic [ktwa_pkg::TIME_W-1:0]  nb_stamp;

    assign ctl.probe = accept;
    assign ctl.upd   = commit && upd_vec[j];
    assign ctl.load  = commit && load_vec[j];
    assign ctl.shift = commit && shift_vec[j];

    // The last cell has no neighbor; what it takes on a removal lies past the
    // new entry count and is never read.
    if (j + 1 < TABLE_DEPTH) begin : g_nb
      assign nb_key   = key_vec[j+1];
      assign nb_stamp = stamp_vec[j+1];
    end else begin : g_end
      assign nb_key   = key_vec[j];
      assign nb_stamp = stamp_vec[j];
    end

    ktwa_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .live_i      (count_q > CNT_W'(j)),
      .probe_id_i  (item_i.vehicle_id),
      .probe_now_i (item_i.now_seconds),
      .timeout_i   (timeout_q),
      .wr_id_i     (id_q),
      .wr_now_i    (now_q),
      .nb_key_i    (nb_key),
      .nb_stamp_i  (nb_stamp),
      .key_o       (key_vec[j]),
      .stamp_o     (stamp_vec[j]),
      .hit_o       (hit_vec[j]),
      .old_o       (old_vec[j])
    );
  end

  ktwa_first #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_first (
    .old_i   (old_vec),
    .key_i   (key_vec),
    .after_o (after_vec),
    .found_o (any_old),
    .key_o   (gone_key)
  );

`ifndef SYNTH
  // Keys are unique, so a report can match at most one cell.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ktwa_pkg::FS_COMMIT) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the reported ID");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_d == ktwa_pkg::ST_ADDED) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("added entry did not grow the count");

  a_purge_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status_d == ktwa_pkg::ST_PURGED) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("purged entry did not shrink the count");
`endif

endmodule

>>> verif/tb_keyed_table_with_aging_core.sv
`timescale 1ns / 1ps
// Testbench for keyed_table_with_aging_core: drives report and purge items through the
// item channel, programs the timeout over the APB-style port, and checks every result
// against an in-bench model of the aging table. Depends on ktwa_pkg and ktwa_chan_if.
module tb_keyed_table_with_aging_core;

  localparam int unsigned TABLE_DEPTH = ktwa_pkg::TABLE_DEPTH;
  localparam int unsigned ID_W        = ktwa_pkg::ID_W;
  localparam int unsigned TIME_W      = ktwa_pkg::TIME_W;
  localparam int unsigned TMO_W       = ktwa_pkg::TMO_W;
  localparam int unsigned STATUS_W    = ktwa_pkg::STATUS_W;
  localparam int unsigned TOTAL_W     = ktwa_pkg::TOTAL_W;
  localparam int unsigned PADDR_W     = ktwa_pkg::PADDR_W;
  localparam int unsigned PDATA_W     = ktwa_pkg::PDATA_W;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned CHUNKS      = 15;
  localparam int unsigned CHUNK_ITEMS = 110;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {ktwa_pkg::REG_TIMEOUT, 2'b00};

  typedef struct packed {
    ktwa_pkg::status_e   status;
    logic [ID_W-1:0]     id;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  // Tracks the table contents and the timeout, and holds the outcomes still owed.
  class table_tracker;
    logic [ID_W-1:0]   keys   [TABLE_DEPTH];
    logic [TIME_W-1:0] stamps [TABLE_DEPTH];
    int unsigned       count;
    logic [TMO_W-1:0]  timeout;
    outcome_t          outcome_q [$];
    int unsigned       fails;

    function new();
      count   = 0;
      timeout = ktwa_pkg::TIMEOUT_RESET;
      fails   = 0;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch in %s: expected %h, got %h", field, want, got);
        end
      end
    endfunction

    function void note_item(logic act, logic [ID_W-1:0] vid, logic [TIME_W-1:0] now);
      outcome_t          o;
      int                hit;
      logic [TIME_W-1:0] age;
      hit = -1;
      if (act == ktwa_pkg::ACT_REPORT) begin
        for (int i = 0; i < count; i++) begin
          if (hit < 0 && keys[i] == vid) hit = i;
        end
        o.id = vid;
        if (hit >= 0) begin
          stamps[hit] = now;
          o.status = ktwa_pkg::ST_UPDATED;
        end else if (count == TABLE_DEPTH) begin
          o.status = ktwa_pkg::ST_DROPPED;
        end else begin
          keys[count]   = vid;
          stamps[count] = now;
          count++;
          o.status = ktwa_pkg::ST_ADDED;
        end
      end else begin
        // The first entry in table order whose age exceeds the timeout goes.
        for (int i = 0; i < count; i++) begin
          age = now - stamps[i];
          if (hit < 0 && age > TIME_W'(timeout)) hit = i;
        end
        if (hit >= 0) begin
          o.status = ktwa_pkg::ST_PURGED;
          o.id = keys[hit];
          for (int j = hit; j + 1 < count; j++) begin
            keys[j]   = keys[j + 1];
            stamps[j] = stamps[j + 1];
          end
          count--;
        end else begin
          o.status = ktwa_pkg::ST_NONE;
          o.id = '0;
        end
      end
      o.total = TOTAL_W'(count);
      outcome_q = {outcome_q, o};
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                               logic [TOTAL_W-1:0] total);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        fails++;
        if (fails <= 10) begin
          $display("result with no item outstanding: status %0d id %h", st, id);
        end
        return;
      end
      o = outcome_q.pop_front();
      compare("status", o.status, st);
      compare("affected_id", o.id, id);
      compare("entry_total", o.total, total);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ktwa_item_if   item_if ();
  ktwa_result_if res_if ();

  table_tracker  tracker;
  int unsigned   tx_idle_pct = 23;
  int unsigned   rx_idle_pct = 84;
  int unsigned   stall_cycles = 0;
  logic [TIME_W-1:0] wall;
  logic [ID_W-1:0]   known_ids [$];

  keyed_table_with_aging_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Both channels are sampled with the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        tracker.note_item(item_if.action, item_if.vehicle_id, item_if.now_seconds);
      end
      if (res_if.valid && res_if.ready) begin
        tracker.check_result(res_if.status, res_if.affected_id, res_if.entry_total);
      end
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic sender_gap();
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic push_item(input logic act, input logic [ID_W-1:0] vid,
                           input logic [TIME_W-1:0] now);
    sender_gap();
    item_if.valid       <= 1'b1;
    item_if.action      <= act;
    item_if.vehicle_id  <= vid;
    item_if.now_seconds <= now;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // Holds the sender back until every outstanding result has been checked.
  task automatic wait_results_done();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic read_timeout(output logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TIMEOUT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    value = prdata;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_timeout(input logic [TMO_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.timeout = value;
    @(posedge clk_i);
    read_timeout(rd);
    tracker.compare("timeout readback", PDATA_W'(value), rd);
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    int                 tmo_plan [CHUNKS];
    int                 tmo;
    bit                 fill;
    int unsigned        purge_pct;
    int unsigned        reuse_pct;
    int unsigned        r;
    logic               act;
    logic [ID_W-1:0]    vid;

    tracker = new();
    tmo_plan = '{10, 65535, 0, 3, -1, 65535, 1, 200, -1, 0, 65535, 5, -1, 2, 10};
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.action      <= ktwa_pkg::ACT_REPORT;
    item_if.vehicle_id  <= '0;
    item_if.now_seconds <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_timeout(rd);
    tracker.compare("timeout after reset", PDATA_W'(ktwa_pkg::TIMEOUT_RESET), rd);

    // Directed part, under the reset timeout of ten seconds.
    push_item(ktwa_pkg::ACT_PURGE,  32'hDEADBEEF, 32'd0);    // purge on an empty table
    push_item(ktwa_pkg::ACT_REPORT, 32'h0000_0000, 32'd0);
    push_item(ktwa_pkg::ACT_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(ktwa_pkg::ACT_REPORT, 32'h0000_0000, 32'd5);   // refresh of a present ID
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd5);
    push_item(ktwa_pkg::ACT_PURGE,  32'hFFFF_FFFF, 32'd16);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd16);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd16);
    push_item(ktwa_pkg::ACT_REPORT, 32'h1234_5678, 32'd100);
    push_item(ktwa_pkg::ACT_REPORT, 32'h9ABC_DEF0, 32'd100);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd110); // age equal to the timeout stays
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd111); // first of two timed-out entries
    push_item(ktwa_pkg::ACT_REPORT, 32'h5555_5555, 32'd1000);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd999);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd999); // time behind the stamp wraps
    push_item(ktwa_pkg::ACT_REPORT, 32'hAAAA_AAAA, 32'd7);
    push_item(ktwa_pkg::ACT_REPORT, 32'hAAAA_AAAA, 32'd17);
    push_item(ktwa_pkg::ACT_PURGE,  32'h0000_0000, 32'd27);
    wall = 32'd27;

    for (int c = 0; c < CHUNKS; c++) begin
      if (c == 5) begin
        tx_idle_pct = 84;
        rx_idle_pct = 23;
      end
      if (c == 10) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_results_done();
      tmo = (tmo_plan[c] < 0) ? int'($urandom_range(65535)) : tmo_plan[c];
      program_timeout(tmo[TMO_W-1:0]);
      // Fill chunks mostly add fresh IDs so that the table runs full.
      fill      = (c % 3 == 1);
      purge_pct = fill ? 2 : 35;
      reuse_pct = fill ? 10 : 60;
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 60) begin
          wall += $urandom_range(3);
        end else if (r < 82) begin
          wall += $urandom_range((tmo >> 2) + 1);
        end else if (r < 95) begin
          wall += tmo + $urandom_range(1);
        end else begin
          wall = $urandom();
        end
        act = ($urandom_range(99) < purge_pct) ? ktwa_pkg::ACT_PURGE : ktwa_pkg::ACT_REPORT;
        if (act == ktwa_pkg::ACT_PURGE) begin
          vid = $urandom();
        end else if (known_ids.size() != 0 && $urandom_range(99) < reuse_pct) begin
          vid = known_ids[$urandom_range(known_ids.size() - 1)];
        end else begin
          vid = $urandom();
          known_ids = {known_ids, vid};
          if (known_ids.size() > 96) void'(known_ids.pop_front());
        end
        push_item(act, vid, wall);
      end
    end

    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.outcome_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
